### design/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int MAX_PAGES = 256;

  localparam int SIDE_W  = 13;
  localparam int PAGE_W  = 8;
  localparam int CNT_W   = 9;
  localparam int GAP_W   = 8;
  localparam int X_W     = 14;
  localparam int Y_W     = 14;
  localparam int TALL_W  = 13;
  localparam int COORD_W = 12;
  localparam int SUM_W   = 16;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [SIDE_W-1:0] SIDE_CAP =
    SIDE_W'((MAX_SIDE < 8191) ? MAX_SIDE : 8191);
  localparam logic [CNT_W-1:0]  PAGE_CAP =
    CNT_W'((MAX_PAGES < 256) ? MAX_PAGES : 256);
  localparam logic [Y_W-1:0]    SHELF_Y_MAX = 14'd16383;

  localparam logic [SIDE_W-1:0] RST_ATLAS_W = 13'd1024;
  localparam logic [SIDE_W-1:0] RST_ATLAS_H = 13'd1024;
  localparam logic [CNT_W-1:0]  RST_PAGES   = 9'd1;
  localparam logic [GAP_W-1:0]  RST_GAP     = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATLAS_WIDTH  = 2'd0,
    REG_ATLAS_HEIGHT = 2'd1,
    REG_PAGES_IN_USE = 2'd2,
    REG_GAP          = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RESTORE = 1'b1
  } action_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [SIDE_W-1:0] aw;
    logic [SIDE_W-1:0] ah;
    logic [CNT_W-1:0]  pages;
    logic [GAP_W-1:0]  gap;
  } cfg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [TALL_W-1:0] tall;
  } cursor_t;

  typedef struct packed {
    action_t           action;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [PAGE_W-1:0] load_page;
    logic [SIDE_W-1:0] load_x;
    logic [SIDE_W-1:0] load_y;
    logic [SIDE_W-1:0] load_shelf;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [PAGE_W-1:0]  page;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } res_t;

endpackage

### design/srp_cfg.sv
// ----------------------------------------------------------------------------
// srp_cfg
// Configuration registers with clamping to effective values.
// ----------------------------------------------------------------------------
module srp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [srp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output srp_pkg::cfg_t                  cfg
);

  logic [srp_pkg::SIDE_W-1:0] atlas_w_r;
  logic [srp_pkg::SIDE_W-1:0] atlas_h_r;
  logic [srp_pkg::CNT_W-1:0]  pages_r;
  logic [srp_pkg::GAP_W-1:0]  gap_r;
  logic [srp_pkg::CNT_W-1:0]  pages_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= srp_pkg::RST_ATLAS_W;
      atlas_h_r <= srp_pkg::RST_ATLAS_H;
      pages_r   <= srp_pkg::RST_PAGES;
      gap_r     <= srp_pkg::RST_GAP;
    end else if (cfg_we) begin
      unique case (srp_pkg::cfg_reg_t'(cfg_index))
        srp_pkg::REG_ATLAS_WIDTH:  atlas_w_r <= cfg_wdata[srp_pkg::SIDE_W-1:0];
        srp_pkg::REG_ATLAS_HEIGHT: atlas_h_r <= cfg_wdata[srp_pkg::SIDE_W-1:0];
        srp_pkg::REG_PAGES_IN_USE: pages_r   <= cfg_wdata[srp_pkg::CNT_W-1:0];
        srp_pkg::REG_GAP:          gap_r     <= cfg_wdata[srp_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign pages_lo = (pages_r == '0) ? srp_pkg::CNT_W'(1) : pages_r;

  always_comb begin
    cfg.aw    = (atlas_w_r > srp_pkg::SIDE_CAP) ? srp_pkg::SIDE_CAP : atlas_w_r;
    cfg.ah    = (atlas_h_r > srp_pkg::SIDE_CAP) ? srp_pkg::SIDE_CAP : atlas_h_r;
    cfg.pages = (pages_lo > srp_pkg::PAGE_CAP) ? srp_pkg::PAGE_CAP : pages_lo;
    cfg.gap   = (gap_r == '0) ? srp_pkg::GAP_W'(1) : gap_r;
  end

endmodule

### design/srp_place.sv
// ----------------------------------------------------------------------------
// srp_place
// Placement logic: restore, shelf move, page move, grant, next cursor.
// ----------------------------------------------------------------------------
module srp_place (
  input  srp_pkg::cfg_t    cfg,
  input  srp_pkg::cursor_t cur,
  input  srp_pkg::req_t    req,
  output srp_pkg::res_t    res,
  output srp_pkg::cursor_t nxt
);

  localparam int SW = srp_pkg::SUM_W;

  logic [SW-1:0] w16, h16, g16, aw16, ah16;
  logic [SW-1:0] ny, x_end1, y_end1;
  logic          bad, x_over, fits, last;
  logic [srp_pkg::X_W-1:0]    x1;
  logic [srp_pkg::Y_W-1:0]    y1;
  logic [srp_pkg::TALL_W-1:0] t1;
  logic [srp_pkg::CNT_W-1:0]  pm1;
  logic [srp_pkg::CNT_W-1:0]  page_inc;

  always_comb begin
    w16  = SW'(req.w);
    h16  = SW'(req.h);
    g16  = SW'(cfg.gap);
    aw16 = SW'(cfg.aw);
    ah16 = SW'(cfg.ah);

    bad = (req.w == '0) || (req.h == '0) ||
          (w16 + (g16 << 1) > aw16) || (h16 + (g16 << 1) > ah16);

    // shelf move
    x_over = SW'(cur.x) + w16 + g16 > aw16;
    ny     = SW'(cur.y) + SW'(cur.tall) + g16;
    x1     = x_over ? srp_pkg::X_W'(cfg.gap) : cur.x;
    y1     = !x_over ? cur.y :
             (ny > SW'(srp_pkg::SHELF_Y_MAX)) ? srp_pkg::SHELF_Y_MAX : ny[srp_pkg::Y_W-1:0];
    t1     = x_over ? '0 : cur.tall;

    y_end1 = SW'(y1) + h16 + g16;
    fits   = y_end1 <= ah16;
    x_end1 = SW'(x1) + w16 + g16;

    page_inc = srp_pkg::CNT_W'(cur.page) + srp_pkg::CNT_W'(1);
    last     = page_inc >= cfg.pages;
    pm1      = cfg.pages - srp_pkg::CNT_W'(1);

    res = '0;
    nxt = cur;
    priority if (req.action == srp_pkg::ACT_RESTORE) begin
      nxt.page = (srp_pkg::CNT_W'(req.load_page) > pm1) ?
                 pm1[srp_pkg::PAGE_W-1:0] : req.load_page;
      nxt.x    = srp_pkg::X_W'(req.load_x);
      nxt.y    = srp_pkg::Y_W'(req.load_y);
      nxt.tall = req.load_shelf;
    end else if (bad) begin
      nxt = cur;
    end else if (fits) begin
      res.granted = 1'b1;
      res.page    = cur.page;
      res.x       = x1[srp_pkg::COORD_W-1:0];
      res.y       = y1[srp_pkg::COORD_W-1:0];
      nxt.x       = x_end1[srp_pkg::X_W-1:0];
      nxt.y       = y1;
      nxt.tall    = (req.h > t1) ? req.h : t1;
    end else if (last) begin
      // failed; shelf move sticks
      nxt.x    = x1;
      nxt.y    = y1;
      nxt.tall = t1;
    end else begin
      // fresh page always fits
      res.granted = 1'b1;
      res.page    = page_inc[srp_pkg::PAGE_W-1:0];
      res.x       = srp_pkg::COORD_W'(cfg.gap);
      res.y       = srp_pkg::COORD_W'(cfg.gap);
      nxt.page    = page_inc[srp_pkg::PAGE_W-1:0];
      nxt.x       = srp_pkg::X_W'(w16 + (g16 << 1));
      nxt.y       = srp_pkg::Y_W'(cfg.gap);
      nxt.tall    = req.h;
    end
  end

endmodule

### design/shelf_rect_packer.sv
// A request passes through the input register, then the result register.
// Throughput: one request per cycle while the result side is not stalled; the cursor
// update closes through the placement logic between input and result registers.
// Reset (rst_n low, synchronous): registers go to 1024/1024/1 page/gap 1, cursor to
// page 0 at (1,1) with an empty shelf, both pipeline stages empty.
// ----------------------------------------------------------------------------
// shelf_rect_packer
// Shelf next-fit rectangle allocator over multiple atlas pages.
// ----------------------------------------------------------------------------
module shelf_rect_packer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // rect_width, rect_height, load_page, load_x, load_y, load_shelf, zero pad
  input  logic [srp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_page, place_x, place_y
  output logic [srp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // granted
  output logic [0:0]                      out_tuser
);

  srp_pkg::cfg_t    cfg;
  srp_pkg::req_t    req_r, req_in;
  srp_pkg::res_t    res_r, res_nxt;
  srp_pkg::cursor_t cur_r, cur_nxt;
  logic             req_v_r, out_v_r, adv;

  srp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srp_place u_place (
    .cfg (cfg),
    .cur (cur_r),
    .req (req_r),
    .res (res_nxt),
    .nxt (cur_nxt)
  );

  always_comb begin
    req_in.action     = srp_pkg::action_t'(in_tuser[0]);
    req_in.w          = in_tdata[12:0];
    req_in.h          = in_tdata[25:13];
    req_in.load_page  = in_tdata[33:26];
    req_in.load_x     = in_tdata[46:34];
    req_in.load_y     = in_tdata[59:47];
    req_in.load_shelf = in_tdata[72:60];
  end

  assign adv       = !out_v_r || out_tready;
  assign in_tready = !req_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
      cur_r   <= '{page: '0, x: srp_pkg::X_W'(1), y: srp_pkg::Y_W'(1), tall: '0};
    end else begin
      if (in_tready) req_v_r <= in_tvalid;
      if (adv) begin
        out_v_r <= req_v_r;
        if (req_v_r) cur_r <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) req_r <= req_in;
    if (adv && req_v_r) res_r <= res_nxt;
  end

  assign out_tvalid   = out_v_r;
  assign out_tuser[0] = res_r.granted;
  assign out_tdata    = {res_r.y, res_r.x, res_r.page};

endmodule

### design/srp_checker.sv
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks for the shelf rectangle packer, bound to the top level.
// ----------------------------------------------------------------------------
module srp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [srp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);

  // results vanish on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // refused requests and restores carry an all-zero result
  a_zero_on_deny: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("denied result carries nonzero placement");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind shelf_rect_packer srp_checker u_srp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/shelf_rect_packer_tb.sv
// ----------------------------------------------------------------------------
// shelf_rect_packer_tb
// Drives allocate and restore requests through the packer under random
// back-pressure and checks every placement against a cycle-free model of
// the shelf cursor, across several atlas, page-count and gap settings.
// ----------------------------------------------------------------------------
module shelf_rect_packer_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;

  class atlas_placement_model;
    int unsigned reg_aw, reg_ah, reg_pages, reg_gap;
    int unsigned cur_page, cur_x, cur_y, cur_tall;
    srp_pkg::res_t placements_due[$];
    int unsigned mismatches;

    function new();
      reg_aw = srp_pkg::RST_ATLAS_W;
      reg_ah = srp_pkg::RST_ATLAS_H;
      reg_pages = srp_pkg::RST_PAGES;
      reg_gap = srp_pkg::RST_GAP;
      cur_page = 0;
      cur_x = 1;
      cur_y = 1;
      cur_tall = 0;
      mismatches = 0;
    endfunction

    function void write_reg(srp_pkg::cfg_reg_t idx, int unsigned v);
      case (idx)
        srp_pkg::REG_ATLAS_WIDTH:  reg_aw = v & 32'h1FFF;
        srp_pkg::REG_ATLAS_HEIGHT: reg_ah = v & 32'h1FFF;
        srp_pkg::REG_PAGES_IN_USE: reg_pages = v & 32'h1FF;
        srp_pkg::REG_GAP:          reg_gap = v & 32'hFF;
        default: ;
      endcase
    endfunction

    function srp_pkg::res_t place_rect(srp_pkg::req_t r);
      int unsigned aw, ah, g, pages, ny, w, h, lp;
      srp_pkg::res_t e;
      e = '0;
      aw = (reg_aw > srp_pkg::MAX_SIDE) ? srp_pkg::MAX_SIDE : reg_aw;
      ah = (reg_ah > srp_pkg::MAX_SIDE) ? srp_pkg::MAX_SIDE : reg_ah;
      g = (reg_gap == 0) ? 1 : reg_gap;
      pages = (reg_pages == 0) ? 1 : reg_pages;
      if (pages > srp_pkg::MAX_PAGES) pages = srp_pkg::MAX_PAGES;
      if (pages > 256) pages = 256;
      w = r.w;
      h = r.h;
      if (r.action == srp_pkg::ACT_RESTORE) begin
        lp = r.load_page;
        cur_page = (lp > pages - 1) ? pages - 1 : lp;
        cur_x = r.load_x;
        cur_y = r.load_y;
        cur_tall = r.load_shelf;
        return e;
      end
      if (w == 0 || h == 0) return e;
      if (w + 2 * g > aw || h + 2 * g > ah) return e;
      // shelf move, then page move; a fresh page always fits
      for (int n = 0; n < 3; n++) begin
        if (cur_x + w + g > aw) begin
          ny = cur_y + cur_tall + g;
          cur_x = g;
          cur_y = (ny > 16383) ? 16383 : ny;
          cur_tall = 0;
        end
        if (cur_y + h + g <= ah) begin
          e.granted = 1'b1;
          e.page = cur_page[srp_pkg::PAGE_W-1:0];
          e.x = cur_x[srp_pkg::COORD_W-1:0];
          e.y = cur_y[srp_pkg::COORD_W-1:0];
          cur_x = cur_x + w + g;
          if (h > cur_tall) cur_tall = h;
          break;
        end
        if (cur_page + 1 >= pages) break;
        cur_page = cur_page + 1;
        cur_x = g;
        cur_y = g;
        cur_tall = 0;
      end
      return e;
    endfunction

    function void note_request(srp_pkg::req_t r);
      placements_due.push_back(place_rect(r));
    endfunction

    function void check_placement(srp_pkg::res_t got);
      srp_pkg::res_t want;
      if (placements_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: %s",
                   $realtime,
                   $sformatf("granted=%0d page=%0d x=%0d y=%0d",
                             got.granted, got.page, got.x, got.y));
        return;
      end
      want = placements_due.pop_front();
      if (got.granted !== want.granted || got.page !== want.page ||
          got.x !== want.x || got.y !== want.y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: placement mismatch: exp %s, got %s",
                   $realtime,
                   $sformatf("granted=%0d page=%0d x=%0d y=%0d",
                             want.granted, want.page, want.x, want.y),
                   $sformatf("granted=%0d page=%0d x=%0d y=%0d",
                             got.granted, got.page, got.x, got.y));
      end
    endfunction

    function int unsigned pending();
      return placements_due.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [srp_pkg::CFG_DATA_W-1:0]  cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  // rect_width, rect_height, load_page, load_x, load_y, load_shelf
  logic [srp_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]                      in_tuser;   // action
  logic                            out_tvalid;
  logic                            out_tready;
  logic [srp_pkg::OUT_TDATA_W-1:0] out_tdata;  // out_page, place_x, place_y
  logic [0:0]                      out_tuser;  // granted

  atlas_placement_model tracker;
  int unsigned cur_aw, cur_ah;
  int unsigned src_idle, snk_idle;
  int unsigned hold_ask, hold_left;
  int unsigned cycles;

  shelf_rect_packer uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("shelf_rect_packer_tb: errors");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_ask > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_ask;
      hold_ask = 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  function automatic logic [srp_pkg::IN_TDATA_W-1:0] pack_request(srp_pkg::req_t r);
    return {7'd0, r.load_shelf, r.load_y, r.load_x, r.load_page, r.h, r.w};
  endfunction

  function automatic srp_pkg::req_t unpack_request(logic [srp_pkg::IN_TDATA_W-1:0] d,
                                                   logic [0:0] u);
    srp_pkg::req_t r;
    r.action = srp_pkg::action_t'(u[0]);
    r.w = d[12:0];
    r.h = d[25:13];
    r.load_page = d[33:26];
    r.load_x = d[46:34];
    r.load_y = d[59:47];
    r.load_shelf = d[72:60];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.note_request(unpack_request(in_tdata, in_tuser));
  end

  always @(posedge clk) begin
    srp_pkg::res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.granted = out_tuser[0];
      got.page = out_tdata[7:0];
      got.x = out_tdata[19:8];
      got.y = out_tdata[31:20];
      tracker.check_placement(got);
    end
  end

  function automatic srp_pkg::req_t alloc_req(int unsigned w, int unsigned h);
    srp_pkg::req_t r;
    r.action = srp_pkg::ACT_ALLOC;
    r.w = srp_pkg::SIDE_W'(w);
    r.h = srp_pkg::SIDE_W'(h);
    r.load_page = srp_pkg::PAGE_W'($urandom);
    r.load_x = srp_pkg::SIDE_W'($urandom);
    r.load_y = srp_pkg::SIDE_W'($urandom);
    r.load_shelf = srp_pkg::SIDE_W'($urandom);
    return r;
  endfunction

  function automatic srp_pkg::req_t restore_req(int unsigned pg, int unsigned x,
                                                int unsigned y, int unsigned tall);
    srp_pkg::req_t r;
    r.action = srp_pkg::ACT_RESTORE;
    r.w = srp_pkg::SIDE_W'($urandom);
    r.h = srp_pkg::SIDE_W'($urandom);
    r.load_page = srp_pkg::PAGE_W'(pg);
    r.load_x = srp_pkg::SIDE_W'(x);
    r.load_y = srp_pkg::SIDE_W'(y);
    r.load_shelf = srp_pkg::SIDE_W'(tall);
    return r;
  endfunction

  function automatic srp_pkg::req_t rand_request();
    int unsigned ea, eh, wmax, hmax, pick;
    ea = (cur_aw > srp_pkg::MAX_SIDE) ? srp_pkg::MAX_SIDE : ((cur_aw == 0) ? 1 : cur_aw);
    eh = (cur_ah > srp_pkg::MAX_SIDE) ? srp_pkg::MAX_SIDE : ((cur_ah == 0) ? 1 : cur_ah);
    wmax = ($urandom_range(0, 1) == 0) ? ea / 8 : ea / 2;
    hmax = ($urandom_range(0, 1) == 0) ? eh / 8 : eh / 2;
    if (wmax == 0) wmax = 1;
    if (hmax == 0) hmax = 1;
    pick = $urandom_range(0, 99);
    if (pick < 82)
      return alloc_req($urandom_range(1, wmax), $urandom_range(1, hmax));
    else if (pick < 86)
      return ($urandom_range(0, 1) == 0) ? alloc_req(0, $urandom_range(0, hmax))
                                         : alloc_req($urandom_range(0, wmax), 0);
    else if (pick < 94)
      return restore_req($urandom_range(0, 255), $urandom_range(0, ea),
                         $urandom_range(0, eh), $urandom_range(0, hmax));
    else if (pick < 97)
      return restore_req($urandom, $urandom, $urandom, $urandom);
    else
      return alloc_req($urandom_range(0, 8191), $urandom_range(0, 8191));
  endfunction

  task automatic send(srp_pkg::req_t r);
    in_tvalid <= 1'b1;
    in_tdata <= pack_request(r);
    in_tuser <= r.action;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(0, 99) < src_idle) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(srp_pkg::cfg_reg_t idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= srp_pkg::CFG_DATA_W'(v);
    @(posedge clk);
    tracker.write_reg(idx, v);
  endtask

  task automatic apply_cfg(int unsigned aw, int unsigned ah, int unsigned pages,
                           int unsigned g);
    write_reg(srp_pkg::REG_ATLAS_WIDTH, aw);
    write_reg(srp_pkg::REG_ATLAS_HEIGHT, ah);
    write_reg(srp_pkg::REG_PAGES_IN_USE, pages);
    write_reg(srp_pkg::REG_GAP, g);
    cfg_we <= 1'b0;
    cur_aw = aw & 32'h1FFF;
    cur_ah = ah & 32'h1FFF;
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    src_idle = 38;
    snk_idle = 38;
    hold_ask = 0;
    cur_aw = srp_pkg::RST_ATLAS_W;
    cur_ah = srp_pkg::RST_ATLAS_H;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: refusals, exact fit, full page, boundary shelf_y
    send(alloc_req(0, 5));
    send(alloc_req(5, 0));
    send(alloc_req(1023, 10));
    send(alloc_req(10, 1023));
    send(alloc_req(1022, 1022));
    send(alloc_req(10, 10));
    send(restore_req(255, 8191, 8191, 8191));
    send(alloc_req(3, 3));
    send(restore_req(0, 1, 1, 0));
    send(alloc_req(8191, 8191));
    send(restore_req(0, 0, 0, 0));
    send(alloc_req(1, 1));
    settle();

    // oversize width clamps, zero height refuses all
    apply_cfg(8191, 0, 1, 1);
    send(alloc_req(1, 1));
    send(alloc_req(4094, 1));
    settle();

    // largest page, page count over range, zero gap
    apply_cfg(4096, 4096, 511, 0);
    send(restore_req(255, 8191, 8191, 8191));
    send(alloc_req(4094, 4094));
    send(restore_req(0, 1, 1, 0));
    send(alloc_req(4094, 4094));
    send(alloc_req(1, 1));
    settle();

    // widest gap, zero page count, shelf_y saturation
    apply_cfg(4096, 4096, 0, 255);
    send(restore_req(7, 8191, 8191, 8191));
    send(alloc_req(1, 1));
    send(restore_req(0, 255, 255, 0));
    send(alloc_req(3586, 3586));
    settle();

    apply_cfg(0, 1, 256, 1);
    send(alloc_req(1, 1));
    send(alloc_req(8191, 8191));

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: apply_cfg($urandom_range(64, 256), $urandom_range(64, 256),
                     $urandom_range(1, 4), $urandom_range(0, 3));
        1: apply_cfg($urandom_range(16, 100), $urandom_range(16, 100),
                     $urandom_range(1, 8), $urandom_range(0, 2));
        2: apply_cfg($urandom_range(100, 400), $urandom_range(50, 300),
                     $urandom_range(2, 6), $urandom_range(1, 4));
        3: apply_cfg(4096, 4096, 256, 1);
        4: apply_cfg($urandom_range(32, 128), $urandom_range(32, 128),
                     $urandom_range(1, 3), $urandom_range(0, 3));
        5: apply_cfg(8191, 8191, 511, 255);
        6: apply_cfg($urandom_range(1, 24), $urandom_range(1, 24),
                     $urandom_range(0, 3), $urandom_range(0, 2));
        7: apply_cfg($urandom_range(200, 1200), $urandom_range(200, 1200),
                     $urandom_range(256, 511), $urandom_range(0, 10));
        8: apply_cfg($urandom_range(100, 4096), $urandom_range(100, 4096),
                     $urandom_range(0, 511), $urandom_range(0, 255));
        9: apply_cfg($urandom_range(48, 160), $urandom_range(48, 160),
                     $urandom_range(1, 5), $urandom_range(1, 2));
        10: apply_cfg($urandom_range(64, 256), $urandom_range(16, 64),
                      $urandom_range(1, 2), $urandom_range(0, 1));
        default: apply_cfg($urandom_range(128, 512), $urandom_range(128, 512),
                           $urandom_range(1, 16), $urandom_range(0, 8));
      endcase
      src_idle = (ph == 2) ? 0 : 38;
      snk_idle = (ph == 2) ? 0 : 38;
      if (ph == 4 || ph == 9) hold_ask = 150;
      repeat (152) send(rand_request());
    end

    settle();
    repeat (6) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("shelf_rect_packer_tb: clean");
    else
      $display("shelf_rect_packer_tb: errors");
    $finish;
  end

endmodule
